### hdl/bmq_pkg.sv
// bmq_pkg: shared types, codes and defaults of the bounded message queue
// used by every module of the block, no dependencies
package bmq_pkg;

  localparam int SLOT_BYTES_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int WAITER_SLOTS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSGS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_EN  = 2'd2;

  localparam logic [2:0] CMD_SEND      = 3'd0;
  localparam logic [2:0] CMD_RECV      = 3'd1;
  localparam logic [2:0] CMD_WAIT_AV   = 3'd2;
  localparam logic [2:0] CMD_WAIT_FULL = 3'd3;
  localparam logic [2:0] CMD_CANCEL    = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_EVENT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SIZE      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_ALREADY   = 3'd4;
  localparam logic [2:0] ST_LIST_FULL = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] requester;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] rx_buf_len;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;
    logic [7:0] done_requester;
    logic       completion;
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    R_IDLE  = 3'd0,
    R_FINAL = 3'd1,
    R_AVSW  = 3'd2,
    R_FULSW = 3'd3,
    R_RECV  = 3'd4
  } route_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic sweep_av;
    logic sweep_full;
    logic emit_event;
    logic emit_final;
    logic rd_issue;
    logic emit_byte;
  } ctl_cmd_t;

  typedef struct packed {
    route_t route;
    logic   out_free;
    logic   sweep_go;
    logic   sweep_end;
    logic   fills;
    logic   event_en;
    logic   byte_last;
  } dp_stat_t;

endpackage

### hdl/bmq_ctrl.sv
// bmq_ctrl: sequencer of the message queue, one word in flight at a time
// depends on bmq_pkg
module bmq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bmq_pkg::dp_stat_t stat,
  output bmq_pkg::ctl_cmd_t cmd
);
  import bmq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_AVSW   = 8'b0000_0100,
    S_EVENT  = 8'b0000_1000,
    S_FULSW  = 8'b0001_0000,
    S_FINAL  = 8'b0010_0000,
    S_RD     = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.route)
          R_FINAL: state_nxt = S_FINAL;
          R_AVSW:  state_nxt = S_AVSW;
          R_FULSW: state_nxt = S_FULSW;
          R_RECV:  state_nxt = S_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_AVSW: begin
        if (stat.sweep_go && stat.sweep_end) begin
          if (stat.event_en)   state_nxt = S_EVENT;
          else if (stat.fills) state_nxt = S_FULSW;
          else                 state_nxt = S_FINAL;
        end
      end
      S_EVENT:  if (stat.out_free) state_nxt = stat.fills ? S_FULSW : S_FINAL;
      S_FULSW:  if (stat.sweep_go && stat.sweep_end) state_nxt = S_FINAL;
      S_FINAL:  if (stat.out_free) state_nxt = S_IDLE;
      S_RD:     state_nxt = S_EMIT;
      S_EMIT:   if (stat.out_free) state_nxt = stat.byte_last ? S_IDLE : S_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cmd.accept     = (state_r == S_IDLE) && in_valid;
  assign cmd.decode     = (state_r == S_DECODE);
  assign cmd.sweep_av   = (state_r == S_AVSW);
  assign cmd.sweep_full = (state_r == S_FULSW);
  assign cmd.emit_event = (state_r == S_EVENT);
  assign cmd.emit_final = (state_r == S_FINAL);
  assign cmd.rd_issue   = (state_r == S_RD);
  assign cmd.emit_byte  = (state_r == S_EMIT);

endmodule

### hdl/bmq_dp.sv
// bmq_dp: message store, queue pointers, waiter lists and output register
// depends on bmq_pkg, driven by bmq_ctrl
module bmq_dp #(
  parameter int SLOT_BYTES   = bmq_pkg::SLOT_BYTES_DEF,
  parameter int QUEUE_DEPTH  = bmq_pkg::QUEUE_DEPTH_DEF,
  parameter int WAITER_SLOTS = bmq_pkg::WAITER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bmq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  bmq_pkg::in_word_t               in_word,
  input  bmq_pkg::ctl_cmd_t               cmd,
  output bmq_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bmq_pkg::out_word_t              out_word
);
  import bmq_pkg::*;

  localparam int BW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int MD = QUEUE_DEPTH * SLOT_BYTES;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  logic [6:0]    max_bytes_r;
  logic [4:0]    max_msgs_r;
  logic          event_en_r;
  in_word_t      it_r;
  logic [7:0]    mem [MD];
  logic [7:0]    rdata_r;
  logic [LW-1:0] slot_len_r [QUEUE_DEPTH];
  logic [QW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [7:0]    inlen_r;
  logic          lost_r;
  logic [7:0]    av_id_r [WAITER_SLOTS];
  logic [WAITER_SLOTS-1:0] av_vld_r;
  logic [7:0]    fu_id_r [WAITER_SLOTS];
  logic [WAITER_SLOTS-1:0] fu_vld_r;
  out_word_t     fin_r, fin_nxt;
  logic          fills_r;
  logic [LW-1:0] slen_r;
  logic [BW-1:0] idx_r;
  logic [WW-1:0] sw_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [LW-1:0] eff_m;
  logic [CW-1:0] eff_q;
  logic [7:0]    len_nxt;
  logic          store_ok, room, lost_nxt, too_long, q_full, fills_nxt, commit;
  logic          av_match, av_free, fu_match, fu_free;
  logic [WW-1:0] av_midx, av_fidx, fu_fidx;
  route_t        route;
  logic          out_free, sweep_on, cur_hit, sweep_go, sweep_end, byte_last;
  logic          emit;
  out_word_t     emit_word;
  logic [AW-1:0] wr_addr, rd_addr;

  // clamp the configured limits
  always_comb begin
    if (max_bytes_r == 7'd0)               eff_m = LW'(1);
    else if (int'(max_bytes_r) > SLOT_BYTES) eff_m = LW'(SLOT_BYTES);
    else                                   eff_m = LW'(max_bytes_r);
    if (max_msgs_r == 5'd0)                eff_q = CW'(1);
    else if (int'(max_msgs_r) > QUEUE_DEPTH) eff_q = CW'(QUEUE_DEPTH);
    else                                   eff_q = CW'(max_msgs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 7'd64;
      max_msgs_r  <= 5'd16;
      event_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BYTES: max_bytes_r <= cfg_wdata;
        CFG_MAX_MSGS:  max_msgs_r  <= cfg_wdata[4:0];
        CFG_EVENT_EN:  event_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) it_r <= in_word;
  end

  // waiter list search
  always_comb begin
    av_match = 1'b0; av_midx = '0; av_free = 1'b0; av_fidx = '0;
    fu_match = 1'b0; fu_free = 1'b0; fu_fidx = '0;
    for (int i = 0; i < WAITER_SLOTS; i++) begin
      if (av_vld_r[i] && av_id_r[i] == it_r.requester && !av_match) begin
        av_match = 1'b1; av_midx = WW'(i);
      end
      if (!av_vld_r[i] && !av_free) begin
        av_free = 1'b1; av_fidx = WW'(i);
      end
      if (fu_vld_r[i] && fu_id_r[i] == it_r.requester && !fu_match) begin
        fu_match = 1'b1;
      end
      if (!fu_vld_r[i] && !fu_free) begin
        fu_free = 1'b1; fu_fidx = WW'(i);
      end
    end
  end

  assign len_nxt   = (inlen_r == 8'hFF) ? 8'hFF : inlen_r + 8'd1;
  assign store_ok  = int'(inlen_r) < SLOT_BYTES;
  assign room      = int'(count_r) < QUEUE_DEPTH;
  assign lost_nxt  = lost_r | (store_ok & ~room);
  assign too_long  = int'(len_nxt) > int'(eff_m);
  assign q_full    = lost_nxt || (count_r >= eff_q) || !room;
  assign fills_nxt = ({1'b0, count_r} + (CW+1)'(1)) >= {1'b0, eff_q};
  assign commit    = (it_r.cmd == CMD_SEND) && it_r.last_byte && !too_long && !q_full;

  // decode outcome and the closing word
  always_comb begin
    route   = R_IDLE;
    fin_nxt = '0;
    fin_nxt.kind   = KIND_STATUS;
    fin_nxt.status = ST_OK;
    fin_nxt.last   = 1'b1;
    case (it_r.cmd)
      CMD_SEND: begin
        if (it_r.last_byte) begin
          route = R_FINAL;
          if (too_long)            fin_nxt.status = ST_SIZE;
          else if (q_full)         fin_nxt.status = ST_FULL;
          else if (count_r == '0)  route = R_AVSW;
          else if (fills_nxt)      route = R_FULSW;
        end
      end
      CMD_RECV: begin
        route = R_FINAL;
        if (it_r.rx_buf_len != 8'(eff_m)) fin_nxt.status = ST_SIZE;
        else if (count_r == '0)           fin_nxt.status = ST_EMPTY;
        else                              route = R_RECV;
      end
      CMD_WAIT_AV: begin
        route = R_FINAL;
        if (count_r != '0) begin
          fin_nxt.kind = KIND_DONE;
          fin_nxt.done_requester = it_r.requester;
        end else if (av_match) fin_nxt.status = ST_ALREADY;
        else if (!av_free)     fin_nxt.status = ST_LIST_FULL;
      end
      CMD_WAIT_FULL: begin
        route = R_FINAL;
        if (count_r >= eff_q) begin
          fin_nxt.kind = KIND_DONE;
          fin_nxt.done_requester = it_r.requester;
        end else if (fu_match) fin_nxt.status = ST_ALREADY;
        else if (!fu_free)     fin_nxt.status = ST_LIST_FULL;
      end
      CMD_CANCEL: begin
        route = R_FINAL;
        if (av_match) begin
          fin_nxt.kind = KIND_DONE;
          fin_nxt.done_requester = it_r.requester;
          fin_nxt.completion = 1'b1;
        end
      end
      default: route = R_IDLE;
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign sweep_on  = cmd.sweep_av || cmd.sweep_full;
  assign cur_hit   = cmd.sweep_av ? av_vld_r[sw_r] : fu_vld_r[sw_r];
  assign sweep_go  = !cur_hit || out_free;
  assign sweep_end = int'(sw_r) == WAITER_SLOTS - 1;
  assign byte_last = LW'(idx_r) == (eff_m - LW'(1));

  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    if (sweep_on && cur_hit && out_free) begin
      emit = 1'b1;
      emit_word.kind = KIND_DONE;
      emit_word.done_requester = cmd.sweep_av ? av_id_r[sw_r] : fu_id_r[sw_r];
    end else if (cmd.emit_event && out_free) begin
      emit = 1'b1;
      emit_word.kind = KIND_EVENT;
    end else if (cmd.emit_final && out_free) begin
      emit = 1'b1;
      emit_word = fin_r;
    end else if (cmd.emit_byte && out_free) begin
      emit = 1'b1;
      emit_word.kind = KIND_BYTE;
      emit_word.out_byte = (LW'(idx_r) < slen_r) ? rdata_r : 8'd0;
      emit_word.last = byte_last;
    end
  end

  assign wr_addr = AW'(int'(tail_r) * SLOT_BYTES + int'(inlen_r[BW-1:0]));
  assign rd_addr = AW'(int'(head_r) * SLOT_BYTES + int'(idx_r));

  // message store
  always_ff @(posedge clk) begin
    if (cmd.decode && it_r.cmd == CMD_SEND && store_ok && room)
      mem[wr_addr] <= it_r.data_byte;
    if (cmd.rd_issue) rdata_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      fin_r <= fin_nxt;
      if (commit) begin
        slot_len_r[tail_r] <= LW'(len_nxt);
        fills_r <= fills_nxt;
      end
      if (it_r.cmd == CMD_RECV) slen_r <= slot_len_r[head_r];
      if (it_r.cmd == CMD_WAIT_AV && av_free)   av_id_r[av_fidx] <= it_r.requester;
      if (it_r.cmd == CMD_WAIT_FULL && fu_free) fu_id_r[fu_fidx] <= it_r.requester;
    end
    if (emit) out_word_r <= emit_word;
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      inlen_r  <= 8'd0;
      lost_r   <= 1'b0;
      av_vld_r <= '0;
      fu_vld_r <= '0;
      idx_r    <= '0;
      sw_r     <= '0;
    end else begin
      if (cmd.decode) begin
        idx_r <= '0;
        sw_r  <= '0;
        case (it_r.cmd)
          CMD_SEND: begin
            inlen_r <= it_r.last_byte ? 8'd0 : len_nxt;
            lost_r  <= it_r.last_byte ? 1'b0 : lost_nxt;
            if (commit) begin
              tail_r  <= (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
              count_r <= count_r + CW'(1);
            end
          end
          CMD_WAIT_AV:
            if (count_r == '0 && !av_match && av_free) av_vld_r[av_fidx] <= 1'b1;
          CMD_WAIT_FULL:
            if (count_r < eff_q && !fu_match && fu_free) fu_vld_r[fu_fidx] <= 1'b1;
          CMD_CANCEL:
            if (av_match) av_vld_r[av_midx] <= 1'b0;
          default: ;
        endcase
      end
      if (sweep_on && sweep_go) begin
        sw_r <= sweep_end ? '0 : sw_r + WW'(1);
        if (cur_hit) begin
          if (cmd.sweep_av) av_vld_r[sw_r] <= 1'b0;
          else              fu_vld_r[sw_r] <= 1'b0;
        end
      end
      if (cmd.emit_byte && out_free) begin
        if (byte_last) begin
          head_r  <= (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          count_r <= count_r - CW'(1);
        end else begin
          idx_r <= idx_r + BW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (emit)       out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign stat.route     = route;
  assign stat.out_free  = out_free;
  assign stat.sweep_go  = sweep_go;
  assign stat.sweep_end = sweep_end;
  assign stat.fills     = fills_r;
  assign stat.event_en  = event_en_r;
  assign stat.byte_last = byte_last;

endmodule

### hdl/bounded_message_queue_with_waiters.sv
// bounded_message_queue_with_waiters: top level, joins sequencer and datapath
// depends on bmq_pkg, bmq_ctrl, bmq_dp
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | in_word  (bmq_pkg::in_word_t)
//   out     | out | out_valid/out_stall | out_word (bmq_pkg::out_word_t)
//   cfg     | in  | cfg_we              | cfg_index, cfg_wdata
//
// one word at a time: accept, then decode; a send byte that is not the last returns to idle
// waiter sweeps visit each waiter slot in turn, and hold on a hit while the output is stalled
// a receive reads each byte through the registered store read port, then emits it
// synchronous reset, no clearing pass; the output register holds while stalled
module bounded_message_queue_with_waiters #(
  parameter int SLOT_BYTES   = bmq_pkg::SLOT_BYTES_DEF,
  parameter int QUEUE_DEPTH  = bmq_pkg::QUEUE_DEPTH_DEF,
  parameter int WAITER_SLOTS = bmq_pkg::WAITER_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bmq_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bmq_pkg::out_word_t             out_word
);
  import bmq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmq_dp #(
    .SLOT_BYTES   (SLOT_BYTES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .WAITER_SLOTS (WAITER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### hdl/bmq_checker.sv
// bmq_checker: port level assertions of the message queue, with its bind
// depends on bmq_pkg and bounded_message_queue_with_waiters
module bmq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bmq_pkg::out_word_t out_word
);
  import bmq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_EVENT |-> !out_word.last)
    else $error("available event closed a send");

endmodule

bind bounded_message_queue_with_waiters bmq_checker u_bmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
